// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros used by the deframer parser module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define FLD_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// condition implies consequence in the next cycle
`define FLD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: sv/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Types, codes and helper functions of the framed link deframer.
// ----------------------------------------------------------------------------
package fld_pkg;

    // link phase
    typedef enum logic [1:0] {
        PH_HANDSHAKE = 2'd0,
        PH_HEADER    = 2'd1,
        PH_PAYLOAD   = 2'd2,
        PH_CLOSED    = 2'd3
    } phase_t;

    // event codes
    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_HS_OK       = 3'd1,
        EV_HS_BAD      = 3'd2,
        EV_BAD_MAGIC   = 3'd3,
        EV_HDR_DONE    = 3'd4,
        EV_PAYLOAD_END = 3'd5,
        EV_DROPPED     = 3'd6
    } event_t;

    // data byte kind
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_ID      = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    // payload decode status
    typedef enum logic [3:0] {
        DEC_NONE        = 4'd0,
        DEC_CURSOR      = 4'd1,
        DEC_CONFIG      = 4'd2,
        DEC_JPEG        = 4'd3,
        DEC_PNG         = 4'd4,
        DEC_UNSUPPORTED = 4'd5,
        DEC_TOO_SMALL   = 4'd6,
        DEC_SHORT       = 4'd7,
        DEC_NO_CHANGE   = 4'd8
    } decode_t;

    // framing constants
    localparam int          HS_LEN      = 20;
    localparam logic [4:0]  HS_LAST     = 5'(HS_LEN - 1);
    localparam logic [4:0]  HS_MAGIC_N  = 5'd4;
    localparam logic [4:0]  HDR_LAST    = 5'd5;
    localparam int          CAP_DEPTH   = 5;
    localparam logic [2:0]  CAP_FULL    = 3'(CAP_DEPTH);
    localparam logic [7:0]  HDR_MAGIC   = 8'h48;
    localparam logic [7:0]  TYPE_CONFIG = 8'h10;
    localparam logic [7:0]  TYPE_IMAGE  = 8'h11;
    localparam logic [7:0]  TYPE_CURSOR = 8'h12;
    localparam logic [7:0]  TYPE_EXTRA  = 8'h25;
    localparam logic [7:0]  JPEG_SIG0   = 8'hff;
    localparam logic [7:0]  JPEG_SIG1   = 8'hd8;
    localparam logic [7:0]  PNG_SIG0    = 8'h89;
    localparam logic [7:0]  PNG_SIG1    = 8'h50;

    // one buffered input item
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } item_t;

    // one result item
    typedef struct packed {
        event_t      event_res;
        kind_t       data_kind;
        logic [7:0]  data_byte;
        logic        last_of_payload;
        logic [7:0]  pkt_type;
        logic [31:0] pkt_length;
        logic        unknown_type;
        decode_t     decode_status;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [7:0]  name_length;
    } result_t;

    // handshake magic characters
    function automatic logic [7:0] hs_magic(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h4b;
            2'd1:    ch = 8'h53;
            2'd2:    ch = 8'h53;
            default: ch = 8'h31;
        endcase
        return ch;
    endfunction

    // known packet types
    function automatic logic type_known(input logic [7:0] t);
        return (t <= 8'h04) || (t >= 8'h10 && t <= 8'h14) || (t == TYPE_EXTRA);
    endfunction

endpackage

// File: sv/framed_link_deframer.sv
// ----------------------------------------------------------------------------
// framed_link_deframer
// Byte-stream deframer: handshake check, header parse, payload pass-through
// and payload field decode, one result item per received byte.
// ----------------------------------------------------------------------------
//  channel | ports                  | item
//  --------+------------------------+-----------------------------------
//  input   | s_valid/s_ready        | s_rx_byte
//  result  | m_valid/m_ready        | m_event_res ... m_name_length
//
//  one item per cycle sustained while the result is not stalled; each
//  byte passes the input register, decode and the result register in turn
//  synchronous active-low reset returns the link to the handshake phase
//  a stalled result holds the result register; the input register still
//  takes one more item, then s_ready drops until the result drains
// ----------------------------------------------------------------------------
module framed_link_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [1:0]  m_data_kind,
    output logic [7:0]  m_data_byte,
    output logic        m_last_of_payload,
    output logic [7:0]  m_pkt_type,
    output logic [31:0] m_pkt_length,
    output logic        m_unknown_type,
    output logic [3:0]  m_decode_status,
    output logic [15:0] m_value_a,
    output logic [15:0] m_value_b,
    output logic [7:0]  m_name_length
);

    fld_pkg::item_t   item;
    fld_pkg::result_t result;
    fld_pkg::result_t m_result;
    logic             take;
    logic             advance;

    // a byte moves through decode when it is buffered and the result slot is free
    assign advance = item.valid && take;

    fld_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .item      (item)
    );

    fld_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (item.rx_byte),
        .result  (result)
    );

    fld_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .take     (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // result fields to ports
    assign m_event_res       = m_result.event_res;
    assign m_data_kind       = m_result.data_kind;
    assign m_data_byte       = m_result.data_byte;
    assign m_last_of_payload = m_result.last_of_payload;
    assign m_pkt_type        = m_result.pkt_type;
    assign m_pkt_length      = m_result.pkt_length;
    assign m_unknown_type    = m_result.unknown_type;
    assign m_decode_status   = m_result.decode_status;
    assign m_value_a         = m_result.value_a;
    assign m_value_b         = m_result.value_b;
    assign m_name_length     = m_result.name_length;

endmodule

// File: sv/fld_in_stage.sv
// ----------------------------------------------------------------------------
// fld_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module fld_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_rx_byte,
    input  logic           advance,
    output fld_pkg::item_t item
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // free slot, or slot empties this cycle
    assign s_ready = !valid_reg || advance;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

// File: sv/fld_parser.sv
// ----------------------------------------------------------------------------
// fld_parser
// Link state and per-byte decode: handshake check, header parse, payload
// streaming and end-of-payload field decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fld_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [7:0]       rx_byte,
    output fld_pkg::result_t result
);

    fld_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  byte_count_reg, byte_count_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        mismatch_reg, mismatch_next;
    logic        magic_bad_reg, magic_bad_next;
    logic [7:0]  cur_type_reg, cur_type_next;
    logic [31:0] length_reg, length_next;
    logic [2:0]  pay_idx_reg, pay_idx_next;
    logic [7:0]  cap_reg [fld_pkg::CAP_DEPTH];
    logic [7:0]  cap_view [fld_pkg::CAP_DEPTH];
    logic        cap_we;
    logic [31:0] rem_dec;

    // captured bytes with the current byte bypassed in
    always_comb begin
        for (int i = 0; i < fld_pkg::CAP_DEPTH; i++) begin
            cap_view[i] = (phase_reg == fld_pkg::PH_PAYLOAD && pay_idx_reg == 3'(i))
                        ? rx_byte : cap_reg[i];
        end
    end

    assign rem_dec = remaining_reg - 32'd1;
    assign cap_we  = advance && phase_reg == fld_pkg::PH_PAYLOAD
                  && pay_idx_reg < fld_pkg::CAP_FULL;

    // next state and result
    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        remaining_next  = remaining_reg;
        mismatch_next   = mismatch_reg;
        magic_bad_next  = magic_bad_reg;
        cur_type_next   = cur_type_reg;
        length_next     = length_reg;
        pay_idx_next    = pay_idx_reg;
        result          = '0;

        unique case (phase_reg)
            fld_pkg::PH_HANDSHAKE: begin
                if (byte_count_reg < fld_pkg::HS_MAGIC_N) begin
                    if (rx_byte != fld_pkg::hs_magic(byte_count_reg[1:0])) begin
                        mismatch_next = 1'b1;
                    end
                end else begin
                    result.data_kind = fld_pkg::KIND_ID;
                    result.data_byte = rx_byte;
                end
                if (byte_count_reg >= fld_pkg::HS_LAST) begin
                    result.event_res = mismatch_next ? fld_pkg::EV_HS_BAD : fld_pkg::EV_HS_OK;
                    phase_next       = mismatch_next ? fld_pkg::PH_CLOSED : fld_pkg::PH_HEADER;
                    byte_count_next  = '0;
                end else begin
                    byte_count_next = byte_count_reg + 5'd1;
                end
            end
            fld_pkg::PH_HEADER: begin
                if (byte_count_reg == 5'd0) begin
                    magic_bad_next = (rx_byte != fld_pkg::HDR_MAGIC);
                    length_next    = '0;
                end else if (byte_count_reg == 5'd1) begin
                    cur_type_next = rx_byte;
                end else begin
                    length_next = {length_reg[23:0], rx_byte};
                end
                if (byte_count_reg >= fld_pkg::HDR_LAST) begin
                    byte_count_next = '0;
                    if (magic_bad_reg) begin
                        result.event_res = fld_pkg::EV_BAD_MAGIC;
                        phase_next       = fld_pkg::PH_CLOSED;
                    end else begin
                        result.event_res    = fld_pkg::EV_HDR_DONE;
                        result.pkt_type     = cur_type_reg;
                        result.pkt_length   = length_next;
                        result.unknown_type = !fld_pkg::type_known(cur_type_reg);
                        remaining_next      = length_next;
                        pay_idx_next        = '0;
                        if (length_next != 32'd0) begin
                            phase_next = fld_pkg::PH_PAYLOAD;
                        end else if (cur_type_reg == fld_pkg::TYPE_IMAGE) begin
                            result.decode_status = fld_pkg::DEC_NO_CHANGE;
                        end
                    end
                end else begin
                    byte_count_next = byte_count_reg + 5'd1;
                end
            end
            fld_pkg::PH_PAYLOAD: begin
                result.data_kind    = fld_pkg::KIND_PAYLOAD;
                result.data_byte    = rx_byte;
                result.pkt_type     = cur_type_reg;
                result.pkt_length   = length_reg;
                result.unknown_type = !fld_pkg::type_known(cur_type_reg);
                if (pay_idx_reg < fld_pkg::CAP_FULL) begin
                    pay_idx_next = pay_idx_reg + 3'd1;
                end
                remaining_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    result.event_res       = fld_pkg::EV_PAYLOAD_END;
                    result.last_of_payload = 1'b1;
                    case (cur_type_reg)
                        fld_pkg::TYPE_CONFIG: begin
                            if (length_reg < 32'd5) begin
                                result.decode_status = fld_pkg::DEC_SHORT;
                            end else begin
                                result.decode_status = fld_pkg::DEC_CONFIG;
                                result.value_a       = {cap_view[0], cap_view[1]};
                                result.value_b       = {cap_view[2], cap_view[3]};
                                result.name_length   = cap_view[4];
                            end
                        end
                        fld_pkg::TYPE_CURSOR: begin
                            if (length_reg < 32'd4) begin
                                result.decode_status = fld_pkg::DEC_SHORT;
                            end else begin
                                result.decode_status = fld_pkg::DEC_CURSOR;
                                result.value_a       = {cap_view[0], cap_view[1]};
                                result.value_b       = {cap_view[2], cap_view[3]};
                            end
                        end
                        fld_pkg::TYPE_IMAGE: begin
                            if (length_reg <= 32'd2) begin
                                result.decode_status = fld_pkg::DEC_TOO_SMALL;
                            end else if (cap_view[0] == fld_pkg::JPEG_SIG0
                                      && cap_view[1] == fld_pkg::JPEG_SIG1) begin
                                result.decode_status = fld_pkg::DEC_JPEG;
                            end else if (cap_view[0] == fld_pkg::PNG_SIG0
                                      && cap_view[1] == fld_pkg::PNG_SIG1) begin
                                result.decode_status = fld_pkg::DEC_PNG;
                            end else begin
                                result.decode_status = fld_pkg::DEC_UNSUPPORTED;
                            end
                        end
                        default: begin
                            result.decode_status = fld_pkg::DEC_NONE;
                        end
                    endcase
                    phase_next      = fld_pkg::PH_HEADER;
                    byte_count_next = '0;
                    pay_idx_next    = '0;
                end
            end
            fld_pkg::PH_CLOSED: begin
                result.event_res = fld_pkg::EV_DROPPED;
            end
            default: begin
                phase_next = fld_pkg::PH_CLOSED;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fld_pkg::PH_HANDSHAKE;
            byte_count_reg <= '0;
            remaining_reg  <= '0;
            mismatch_reg   <= 1'b0;
            magic_bad_reg  <= 1'b0;
            cur_type_reg   <= '0;
            length_reg     <= '0;
            pay_idx_reg    <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            remaining_reg  <= remaining_next;
            mismatch_reg   <= mismatch_next;
            magic_bad_reg  <= magic_bad_next;
            cur_type_reg   <= cur_type_next;
            length_reg     <= length_next;
            pay_idx_reg    <= pay_idx_next;
        end
    end

    // first payload bytes of the packet
    always_ff @(posedge aclk) begin
        if (cap_we) begin
            cap_reg[pay_idx_reg] <= rx_byte;
        end
    end

    // a closed link stays closed
    `FLD_ASSERT_NEXT(a_closed_sticky, aclk, aresetn,
        phase_reg == fld_pkg::PH_CLOSED, phase_reg == fld_pkg::PH_CLOSED)
    // header byte counter stays within the six header bytes
    `FLD_ASSERT_SAME(a_hdr_count, aclk, aresetn,
        phase_reg == fld_pkg::PH_HEADER, byte_count_reg <= fld_pkg::HDR_LAST)
    // capture index never runs past the capture buffer
    `FLD_ASSERT_SAME(a_cap_index, aclk, aresetn, 1'b1, pay_idx_reg <= fld_pkg::CAP_FULL)
    // last payload byte always carries the payload end event
    `FLD_ASSERT_SAME(a_last_event, aclk, aresetn,
        advance && result.last_of_payload,
        result.event_res == fld_pkg::EV_PAYLOAD_END && phase_next == fld_pkg::PH_HEADER)

endmodule

// File: sv/fld_out_stage.sv
// ----------------------------------------------------------------------------
// fld_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module fld_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  fld_pkg::result_t  result,
    output logic              take,
    output logic              m_valid,
    input  logic              m_ready,
    output fld_pkg::result_t  m_result
);

    logic             valid_reg;
    fld_pkg::result_t result_reg;

    // register can load when empty or drained this cycle
    assign take = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// File: sim/tb_framed_link_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_link_deframer
// Feeds a valid handshake and a long run of framed packets (config, cursor,
// image, known and unknown types, zero and long lengths) into the deframer,
// then closes the link with a bad header magic and drops the tail. Every
// result item is checked field by field against its directed row or a
// cycle-free link predictor, under changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_framed_link_deframer;

    localparam int          DIR_N        = 26;
    localparam int          RANDOM_UNTIL = 1900;
    localparam int          PHASE_LEN    = 250;
    localparam int          HOLD_AT      = 700;
    localparam int          HOLD_CYCLES  = 50;
    localparam int          PAUSE_AT     = 1300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [7:0]  KNOWN_LOW_TOP = 8'h04;
    localparam logic [7:0]  KNOWN_MID_TOP = 8'h14;
    // handshake magic characters
    localparam logic [7:0]  HS_WORD [4] = '{8'h4b, 8'h53, 8'h53, 8'h31};

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // one directed stimulus row
    typedef struct packed {
        logic [7:0]       rx;
        logic             typed;
        fld_pkg::event_t  ev;
        fld_pkg::kind_t   kind;
        logic [7:0]       ptype;
        logic [31:0]      plen;
        fld_pkg::decode_t dec;
    } dir_row_t;

    // handshake with identifier extremes, then an empty image packet
    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{8'h4b, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h53, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h53, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h31, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h00, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'hff, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h01, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h80, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h7f, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'hfe, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h55, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'haa, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h0f, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'hf0, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h33, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'hcc, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h11, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h22, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h44, 1'b1, fld_pkg::EV_NONE, fld_pkg::KIND_ID,   8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h88, 1'b1, fld_pkg::EV_HS_OK, fld_pkg::KIND_ID,  8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h48, 1'b0, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h11, 1'b0, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h00, 1'b0, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h00, 1'b0, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h00, 1'b0, fld_pkg::EV_NONE, fld_pkg::KIND_NONE, 8'h00, 32'h0, fld_pkg::DEC_NONE},
        '{8'h00, 1'b1, fld_pkg::EV_HDR_DONE, fld_pkg::KIND_NONE, 8'h11, 32'h0,
          fld_pkg::DEC_NO_CHANGE}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_res;
    logic [1:0]  m_data_kind;
    logic [7:0]  m_data_byte;
    logic        m_last_of_payload;
    logic [7:0]  m_pkt_type;
    logic [31:0] m_pkt_length;
    logic        m_unknown_type;
    logic [3:0]  m_decode_status;
    logic [15:0] m_value_a;
    logic [15:0] m_value_b;
    logic [7:0]  m_name_length;

    // stimulus stream and expected results
    logic [7:0]        stream_bytes [$];
    logic              stream_typed [$];
    fld_pkg::result_t  stream_expect [$];
    fld_pkg::result_t  expected_results [$];

    int          accepted_n = 0;
    int          results_n  = 0;
    int          mismatch_n = 0;
    int          cycle_n    = 0;

    // predictor copy of the link state
    fld_pkg::phase_t pr_phase     = fld_pkg::PH_HANDSHAKE;
    logic [4:0]      pr_count     = '0;
    logic [31:0]     pr_left      = '0;
    logic            pr_hs_bad    = 1'b0;
    logic            pr_magic_bad = 1'b0;
    logic [7:0]      pr_type      = '0;
    logic [31:0]     pr_len       = '0;
    logic [2:0]      pr_idx       = '0;
    logic [7:0]      pr_cap [fld_pkg::CAP_DEPTH] = '{default: '0};

    framed_link_deframer uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_res       (m_event_res),
        .m_data_kind       (m_data_kind),
        .m_data_byte       (m_data_byte),
        .m_last_of_payload (m_last_of_payload),
        .m_pkt_type        (m_pkt_type),
        .m_pkt_length      (m_pkt_length),
        .m_unknown_type    (m_unknown_type),
        .m_decode_status   (m_decode_status),
        .m_value_a         (m_value_a),
        .m_value_b         (m_value_b),
        .m_name_length     (m_name_length)
    );

    // clock and reset
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // packet types the link knows
    function automatic logic is_listed_type(input logic [7:0] t);
        return (t <= KNOWN_LOW_TOP) || (t >= fld_pkg::TYPE_CONFIG && t <= KNOWN_MID_TOP)
            || (t == fld_pkg::TYPE_EXTRA);
    endfunction

    // advance the link parser by one received byte
    function automatic fld_pkg::result_t deframe_byte(input logic [7:0] b);
        fld_pkg::result_t r;
        logic [15:0]      va;
        logic [15:0]      vb;
        r = '0;
        case (pr_phase)
            fld_pkg::PH_HANDSHAKE: begin
                if (pr_count < fld_pkg::HS_MAGIC_N) begin
                    if (b != HS_WORD[pr_count[1:0]]) pr_hs_bad = 1'b1;
                end else begin
                    r.data_kind = fld_pkg::KIND_ID;
                    r.data_byte = b;
                end
                if (pr_count >= fld_pkg::HS_LAST) begin
                    r.event_res = pr_hs_bad ? fld_pkg::EV_HS_BAD : fld_pkg::EV_HS_OK;
                    pr_phase    = pr_hs_bad ? fld_pkg::PH_CLOSED : fld_pkg::PH_HEADER;
                    pr_count    = '0;
                end else begin
                    pr_count = pr_count + 5'd1;
                end
            end
            fld_pkg::PH_HEADER: begin
                if (pr_count == 5'd0) begin
                    pr_magic_bad = (b != fld_pkg::HDR_MAGIC);
                    pr_len       = '0;
                end else if (pr_count == 5'd1) begin
                    pr_type = b;
                end else begin
                    pr_len = {pr_len[23:0], b};
                end
                if (pr_count >= fld_pkg::HDR_LAST) begin
                    pr_count = '0;
                    if (pr_magic_bad) begin
                        r.event_res = fld_pkg::EV_BAD_MAGIC;
                        pr_phase    = fld_pkg::PH_CLOSED;
                    end else begin
                        r.event_res    = fld_pkg::EV_HDR_DONE;
                        r.pkt_type     = pr_type;
                        r.pkt_length   = pr_len;
                        r.unknown_type = !is_listed_type(pr_type);
                        pr_left        = pr_len;
                        pr_idx         = '0;
                        if (pr_len != 32'd0) pr_phase = fld_pkg::PH_PAYLOAD;
                        else if (pr_type == fld_pkg::TYPE_IMAGE)
                            r.decode_status = fld_pkg::DEC_NO_CHANGE;
                    end
                end else begin
                    pr_count = pr_count + 5'd1;
                end
            end
            fld_pkg::PH_PAYLOAD: begin
                r.data_kind    = fld_pkg::KIND_PAYLOAD;
                r.data_byte    = b;
                r.pkt_type     = pr_type;
                r.pkt_length   = pr_len;
                r.unknown_type = !is_listed_type(pr_type);
                if (pr_idx < fld_pkg::CAP_FULL) begin
                    pr_cap[pr_idx] = b;
                    pr_idx         = pr_idx + 3'd1;
                end
                pr_left = pr_left - 32'd1;
                // end of payload: decode the captured fields
                if (pr_left == 32'd0) begin
                    va = {pr_cap[0], pr_cap[1]};
                    vb = {pr_cap[2], pr_cap[3]};
                    r.event_res       = fld_pkg::EV_PAYLOAD_END;
                    r.last_of_payload = 1'b1;
                    if (pr_type == fld_pkg::TYPE_CONFIG) begin
                        if (pr_len < 32'd5) begin
                            r.decode_status = fld_pkg::DEC_SHORT;
                        end else begin
                            r.decode_status = fld_pkg::DEC_CONFIG;
                            r.value_a       = va;
                            r.value_b       = vb;
                            r.name_length   = pr_cap[4];
                        end
                    end else if (pr_type == fld_pkg::TYPE_CURSOR) begin
                        if (pr_len < 32'd4) begin
                            r.decode_status = fld_pkg::DEC_SHORT;
                        end else begin
                            r.decode_status = fld_pkg::DEC_CURSOR;
                            r.value_a       = va;
                            r.value_b       = vb;
                        end
                    end else if (pr_type == fld_pkg::TYPE_IMAGE) begin
                        if (pr_len <= 32'd2)
                            r.decode_status = fld_pkg::DEC_TOO_SMALL;
                        else if (pr_cap[0] == fld_pkg::JPEG_SIG0
                              && pr_cap[1] == fld_pkg::JPEG_SIG1)
                            r.decode_status = fld_pkg::DEC_JPEG;
                        else if (pr_cap[0] == fld_pkg::PNG_SIG0
                              && pr_cap[1] == fld_pkg::PNG_SIG1)
                            r.decode_status = fld_pkg::DEC_PNG;
                        else
                            r.decode_status = fld_pkg::DEC_UNSUPPORTED;
                    end
                    pr_phase = fld_pkg::PH_HEADER;
                    pr_count = '0;
                    pr_idx   = '0;
                end
            end
            default: r.event_res = fld_pkg::EV_DROPPED;
        endcase
        return r;
    endfunction

    // idling pattern follows the number of accepted items
    function automatic idle_mode_t idle_mode();
        case ((accepted_n / PHASE_LEN) % 4)
            0:       return IDLE_BOTH;
            1:       return IDLE_NONE;
            2:       return IDLE_SENDER;
            default: return IDLE_RECEIVER;
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        stream_typed.push_back(1'b0);
        stream_expect.push_back('0);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s at result %0d: got %0h want %0h",
                 what, results_n, got, want);
        mismatch_n++;
    endtask

    task automatic field_check(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) flag_mismatch(what, got, want);
    endtask

    // sender: build the byte stream, then offer it
    initial begin : feed
        int               i;
        int               k;
        int               j;
        int               sel;
        int               sig;
        int               gap_pct;
        idle_mode_t       mode;
        dir_row_t         row;
        fld_pkg::result_t want;
        logic [7:0]       ptype;
        logic [7:0]       b;
        logic [31:0]      len;

        s_valid   = 1'b0;
        s_rx_byte = '0;

        // directed rows
        for (k = 0; k < DIR_N; k++) begin
            row  = DIRECTED[k];
            want = '0;
            want.event_res     = row.ev;
            want.data_kind     = row.kind;
            want.data_byte     = (row.kind != fld_pkg::KIND_NONE) ? row.rx : 8'h00;
            want.pkt_type      = row.ptype;
            want.pkt_length    = row.plen;
            want.decode_status = row.dec;
            stream_bytes.push_back(row.rx);
            stream_typed.push_back(row.typed);
            stream_expect.push_back(want);
        end

        // random well-formed packets
        while (stream_bytes.size() < RANDOM_UNTIL) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                ptype = fld_pkg::TYPE_CONFIG;
                len   = $urandom_range(0, 8);
            end else if (sel < 40) begin
                ptype = fld_pkg::TYPE_CURSOR;
                len   = $urandom_range(0, 7);
            end else if (sel < 60) begin
                ptype = fld_pkg::TYPE_IMAGE;
                len   = $urandom_range(0, 10);
            end else if (sel < 75) begin
                case ($urandom_range(0, 2))
                    0:       ptype = 8'($urandom_range(0, KNOWN_LOW_TOP));
                    1:       ptype = 8'($urandom_range(fld_pkg::TYPE_CURSOR + 8'd1,
                                                       KNOWN_MID_TOP));
                    default: ptype = fld_pkg::TYPE_EXTRA;
                endcase
                len = $urandom_range(0, 6);
            end else begin
                ptype = 8'($urandom_range(0, 255));
                len   = $urandom_range(0, 6);
            end
            if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 700);
            queue_byte(fld_pkg::HDR_MAGIC);
            queue_byte(ptype);
            queue_byte(len[31:24]);
            queue_byte(len[23:16]);
            queue_byte(len[15:8]);
            queue_byte(len[7:0]);
            // image payloads: full jpeg, full png, half jpeg signature or none
            sig = $urandom_range(0, 3);
            for (j = 0; j < len; j++) begin
                b = 8'($urandom_range(0, 255));
                if (ptype == fld_pkg::TYPE_IMAGE && j == 0 && sig < 3)
                    b = (sig == 1) ? fld_pkg::PNG_SIG0 : fld_pkg::JPEG_SIG0;
                if (ptype == fld_pkg::TYPE_IMAGE && j == 1 && sig < 2)
                    b = (sig == 1) ? fld_pkg::PNG_SIG1 : fld_pkg::JPEG_SIG1;
                queue_byte(b);
            end
        end

        // bad header magic closes the link, the tail is dropped
        b = 8'($urandom_range(0, 255));
        if (b == fld_pkg::HDR_MAGIC) b = ~b;
        queue_byte(b);
        repeat (5) queue_byte(8'($urandom_range(0, 255)));
        repeat (40) queue_byte(8'($urandom_range(0, 255)));

        wait (aresetn);
        @(negedge aclk);
        for (i = 0; i < stream_bytes.size(); i++) begin
            // let the block drain completely once
            if (i == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (expected_results.size() != 0) @(negedge aclk);
            end
            mode    = idle_mode();
            gap_pct = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_BOTH) ? 7 : 0;
            while ($urandom_range(0, 99) < gap_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_rx_byte <= stream_bytes[i];
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_n == 0 && expected_results.size() == 0)
            $display("tb_framed_link_deframer: done, clean");
        else
            $display("tb_framed_link_deframer: done, errors");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin : drain
        int         stall_pct;
        logic       held;
        idle_mode_t mode;
        m_ready = 1'b0;
        held    = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && accepted_n >= HOLD_AT) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            mode      = idle_mode();
            stall_pct = (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 7 : 0;
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // input accept: predict; result accept: compare with oldest expectation
    always @(posedge aclk) begin
        fld_pkg::result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = deframe_byte(s_rx_byte);
                if (stream_typed[accepted_n]) want = stream_expect[accepted_n];
                expected_results.push_back(want);
                accepted_n++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("unexpected item, event_res", 32'(m_event_res), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    field_check("event_res", 32'(m_event_res), 32'(want.event_res));
                    field_check("data_kind", 32'(m_data_kind), 32'(want.data_kind));
                    field_check("data_byte", 32'(m_data_byte), 32'(want.data_byte));
                    field_check("last_of_payload", 32'(m_last_of_payload),
                                32'(want.last_of_payload));
                    field_check("pkt_type", 32'(m_pkt_type), 32'(want.pkt_type));
                    field_check("pkt_length", m_pkt_length, want.pkt_length);
                    field_check("unknown_type", 32'(m_unknown_type),
                                32'(want.unknown_type));
                    field_check("decode_status", 32'(m_decode_status),
                                32'(want.decode_status));
                    field_check("value_a", 32'(m_value_a), 32'(want.value_a));
                    field_check("value_b", 32'(m_value_b), 32'(want.value_b));
                    field_check("name_length", 32'(m_name_length), 32'(want.name_length));
                end
                results_n++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_n++;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("tb_framed_link_deframer: done, errors");
            $finish;
        end
    end

endmodule

// File: framed_link_deframer.f
+incdir+sv
sv/fld_pkg.sv
sv/fld_in_stage.sv
sv/fld_parser.sv
sv/fld_out_stage.sv
sv/framed_link_deframer.sv
sim/tb_framed_link_deframer.sv
